// ===== rtl/gsa_pkg.sv =====
// Shared types, codes and constant tables for the gas sensor ppm alarm block.
package gsa_pkg;

    // Input item: op code, raw conversion and a directly loaded Ro.
    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  adc_code;
        logic [31:0] ro_value;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [31:0] rs_kohm;
        logic [31:0] ppm;
        logic        ppm_valid;
        logic        alarm;
        logic        calib_done;
        logic        calibrated;
    } out_item_t;

    // Op codes.
    localparam logic [1:0] OP_MEASURE = 2'd0;
    localparam logic [1:0] OP_CALIB   = 2'd1;
    localparam logic [1:0] OP_LOAD_RO = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_SUPPLY    = 3'd0;
    localparam logic [2:0] REG_ADC_REF   = 3'd1;
    localparam logic [2:0] REG_LOAD_RES  = 3'd2;
    localparam logic [2:0] REG_GAIN      = 3'd3;
    localparam logic [2:0] REG_EXPONENT  = 3'd4;
    localparam logic [2:0] REG_THRESHOLD = 3'd5;
    localparam logic [2:0] REG_RATIO     = 3'd6;
    localparam logic [2:0] REG_SAMPLES   = 3'd7;

    localparam logic [31:0] RS_MIN          = 32'd66;
    localparam logic [7:0]  DEFAULT_SAMPLES = 8'd50;
    localparam logic [31:0] ONE_Q30         = 32'h4000_0000;
    localparam logic [31:0] RO_RESET        = 32'd655360;
    localparam logic [23:0] RATIO_ONE       = 24'd65536;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NUM,
        ST_FULL,
        ST_RL,
        ST_RS_DIV,
        ST_RS_WAIT,
        ST_BRANCH,
        ST_LOG_NORM,
        ST_SQ_ISSUE,
        ST_SQ_TAKE,
        ST_EXP_MUL,
        ST_EXP_TAKE,
        ST_POW,
        ST_POW_TAKE,
        ST_GAIN,
        ST_SCALE,
        ST_CAL_ACC,
        ST_CAL_CHK,
        ST_CAL_WAIT1,
        ST_CAL_WAIT2,
        ST_FINISH
    } state_t;

    typedef logic [16:0][31:0] root_tab_t;

    // Floor square root of a 64-bit value, bit pair by bit pair.
    function automatic logic [31:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = 64'd0;
        b   = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    // Unsigned Q2.30 constants 2^(2^-k), each the floor root of the one before.
    function automatic root_tab_t build_roots();
        root_tab_t t;
        t[0] = 32'h8000_0000;
        for (int k = 1; k <= 16; k++)
        begin
            t[k] = isqrt64({2'b00, t[k-1], 30'd0});
        end
        return t;
    endfunction

    localparam root_tab_t ROOT_TAB = build_roots();

endpackage

// ===== rtl/gsa_mul.sv =====
// Shared 32 by 32 unsigned multiplier with a registered product.
module gsa_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    // The product is registered: it is ready in the cycle after the operands.
    always_ff @(posedge clk)
    begin
        p <= 64'(a) * 64'(b);
    end

endmodule

// ===== rtl/gsa_div.sv =====
// Restoring divider: 64-bit dividend, one quotient bit per cycle.
module gsa_div #(
    parameter int DW = 29
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [63:0]   quotient
);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [63:0]   q_reg;
    logic [6:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // One trial subtraction per step.
    assign trial = {rem_reg, q_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    // Control: step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 7'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: dividend bits shift out as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/gas_sensor_ppm_alarm_core.sv =====
// Top level: gas sensor resistance, concentration and alarm sequencer.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    in_data (in_item_t)
//  out      output     out_valid/out_ready  out_data (out_item_t)
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// One item at a time. Rs is computed on the 64-step divider.
// A calibrated measure adds the logarithms of Rs and Ro (normalising shift and
// squarings on the shared multiplier) and the exponent on the root table.
// A completing calibration sample adds two divisions.
// Reset is asynchronous and brings the state, output valid, configuration and calibration registers to their defaults.
// in_ready is low while an item is at work; a held result stalls only the final step.
module gas_sensor_ppm_alarm_core
    import gsa_pkg::*;
#(
    parameter int ADC_MAX           = 1023,
    parameter int MAX_CALIB_SAMPLES = 100
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ADCW   = $clog2(ADC_MAX + 1);
    localparam int FULL_W = 13 + ADCW;
    localparam int VW     = (FULL_W > 23) ? FULL_W : 23;
    localparam int DIV_W  = (VW > 24) ? VW : 24;

    // Configuration registers.
    logic [12:0] supply_reg;
    logic [12:0] adc_ref_reg;
    logic [31:0] load_res_reg;
    logic [31:0] gain_reg;
    logic [19:0] exponent_reg;
    logic [31:0] threshold_reg;
    logic [23:0] ratio_reg;
    logic [7:0]  samples_reg;

    // Persistent state.
    logic [31:0] ro_reg;
    logic        cal_reg;
    logic [39:0] acc_reg;
    logic [7:0]  cnt_reg;

    // Sequencer and work registers.
    state_t      state_reg;
    state_t      state_next;
    in_item_t    item_reg;
    logic [VW-1:0] num_reg;
    logic [31:0] rs_reg;
    logic [31:0] lm_reg;
    logic [4:0]  sh_reg;
    logic [30:0] m_reg;
    logic [15:0] frac_reg;
    logic [3:0]  idx_reg;
    logic        lg_ro_reg;
    logic [20:0] log_rs_reg;
    logic [20:0] log_ro_reg;
    logic [10:0] ei_reg;
    logic [15:0] ef_reg;
    logic [31:0] f_reg;
    logic [3:0]  j_reg;
    logic [31:0] ppm_reg;
    logic        valid_reg;
    logic        alarm_reg;
    logic        done_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    // Shared unit connections.
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      prod;
    logic             div_start;
    logic [63:0]      div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [63:0]      div_q;

    gsa_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    gsa_div #(.DW(DIV_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Derived values.
    logic [VW-1:0] num_clamped;
    logic [VW-1:0] full_val;
    logic [7:0]    n_eff;
    logic [23:0]   ratio_eff;
    logic [31:0]   rs_sat;
    logic [31:0]   ro_sat;
    logic [31:0]   sq_t;
    logic [15:0]   frac_new;
    logic [20:0]   log_new;
    logic [21:0]   l_diff;
    logic [21:0]   l_mag;
    logic [19:0]   b_mag;
    logic          prod_neg;
    logic [42:0]   prod_s;
    logic [39:0]   acc_sum;

    assign num_clamped = (prod[VW-1:0] < VW'(ADC_MAX)) ? VW'(ADC_MAX) : prod[VW-1:0];
    assign full_val    = prod[VW-1:0];
    assign n_eff       = ((samples_reg == 8'd0) || (samples_reg > 8'(MAX_CALIB_SAMPLES)))
                         ? DEFAULT_SAMPLES : samples_reg;
    assign ratio_eff   = (ratio_reg == 24'd0) ? RATIO_ONE : ratio_reg;
    assign rs_sat      = (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF :
                         ((div_q[31:0] < RS_MIN) ? RS_MIN : div_q[31:0]);
    assign ro_sat      = (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF :
                         ((div_q[31:0] == 32'd0) ? 32'd1 : div_q[31:0]);
    assign acc_sum     = acc_reg + {8'd0, rs_reg};

    // Squaring step of the logarithm: keep the mantissa in [1, 2).
    assign sq_t     = prod[61:30];
    always_comb
    begin
        frac_new = frac_reg;
        frac_new[idx_reg] = sq_t[31];
    end
    assign log_new  = {5'd15 - sh_reg, frac_new};

    // Exponent product B * (log2 Rs - log2 Ro), done on magnitudes.
    assign l_diff   = {log_rs_reg[20], log_rs_reg} - {log_ro_reg[20], log_ro_reg};
    assign l_mag    = l_diff[21] ? (22'd0 - l_diff) : l_diff;
    assign b_mag    = exponent_reg[19] ? (20'd0 - exponent_reg) : exponent_reg;
    assign prod_neg = exponent_reg[19] ^ l_diff[21];
    assign prod_s   = prod_neg ? (43'd0 - {1'b0, prod[41:0]}) : {1'b0, prod[41:0]};

    // Final scaling of A * 2^frac by 2^int with saturation.
    logic [11:0] sc_s;
    logic [11:0] sc_n;
    logic [63:0] sc_right;
    logic [63:0] sc_left;
    logic [31:0] ppm_val;

    assign sc_s     = 12'd38 - {ei_reg[10], ei_reg};
    assign sc_n     = 12'd0 - sc_s;
    assign sc_right = prod >> sc_s[5:0];
    assign sc_left  = prod << sc_n[4:0];

    always_comb
    begin
        if (!sc_s[11])
        begin
            if (sc_s >= 12'd64)
            begin
                ppm_val = 32'd0;
            end
            else if (sc_right[63:32] != 32'd0)
            begin
                ppm_val = 32'hFFFF_FFFF;
            end
            else
            begin
                ppm_val = sc_right[31:0];
            end
        end
        else if (prod == 64'd0)
        begin
            ppm_val = 32'd0;
        end
        else if ((sc_n >= 12'd32) || ((prod >> (6'd32 - {1'b0, sc_n[4:0]})) != 64'd0))
        begin
            ppm_val = 32'hFFFF_FFFF;
        end
        else
        begin
            ppm_val = sc_left[31:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:      state_next = ST_FULL;
            ST_FULL:     state_next = ST_RL;
            ST_RL:       state_next = (full_val <= num_reg) ? ST_BRANCH : ST_RS_DIV;
            ST_RS_DIV:   state_next = ST_RS_WAIT;
            ST_RS_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_BRANCH;
                end
            end
            ST_BRANCH:
            begin
                case (item_reg.op)
                    OP_MEASURE: state_next = cal_reg ? ST_LOG_NORM : ST_FINISH;
                    OP_CALIB:   state_next = ST_CAL_ACC;
                    default:    state_next = ST_FINISH;
                endcase
            end
            ST_LOG_NORM:
            begin
                if (lm_reg[31])
                begin
                    state_next = ST_SQ_ISSUE;
                end
            end
            ST_SQ_ISSUE: state_next = ST_SQ_TAKE;
            ST_SQ_TAKE:
            begin
                if (idx_reg != 4'd0)
                begin
                    state_next = ST_SQ_ISSUE;
                end
                else
                begin
                    state_next = lg_ro_reg ? ST_EXP_MUL : ST_LOG_NORM;
                end
            end
            ST_EXP_MUL:  state_next = ST_EXP_TAKE;
            ST_EXP_TAKE: state_next = ST_POW;
            ST_POW:
            begin
                if (ef_reg[4'd15 - j_reg])
                begin
                    state_next = ST_POW_TAKE;
                end
                else if (j_reg == 4'd15)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_POW_TAKE: state_next = (j_reg == 4'd15) ? ST_GAIN : ST_POW;
            ST_GAIN:     state_next = ST_SCALE;
            ST_SCALE:    state_next = ST_FINISH;
            ST_CAL_ACC:  state_next = ST_CAL_CHK;
            ST_CAL_CHK:  state_next = (cnt_reg >= n_eff) ? ST_CAL_WAIT1 : ST_FINISH;
            ST_CAL_WAIT1:
            begin
                if (div_done)
                begin
                    state_next = ST_CAL_WAIT2;
                end
            end
            ST_CAL_WAIT2:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Shared unit operands for each state.
    always_comb
    begin
        mul_a        = 32'd0;
        mul_b        = 32'd0;
        div_start    = 1'b0;
        div_dividend = 64'd0;
        div_divisor  = DIV_W'(num_reg);
        case (state_reg)
            ST_NUM:
            begin
                mul_a = 32'(item_reg.adc_code);
                mul_b = 32'(adc_ref_reg);
            end
            ST_FULL:
            begin
                mul_a = 32'(supply_reg);
                mul_b = 32'(ADC_MAX);
            end
            ST_RL:
            begin
                mul_a = load_res_reg;
                mul_b = 32'(full_val - num_reg);
            end
            ST_RS_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = prod;
            end
            ST_SQ_ISSUE:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            ST_EXP_MUL:
            begin
                mul_a = 32'(b_mag);
                mul_b = 32'(l_mag);
            end
            ST_POW:
            begin
                mul_a = f_reg;
                mul_b = ROOT_TAB[5'(j_reg) + 5'd1];
            end
            ST_GAIN:
            begin
                mul_a = gain_reg;
                mul_b = f_reg;
            end
            ST_CAL_CHK:
            begin
                div_start    = cnt_reg >= n_eff;
                div_dividend = {24'd0, acc_reg};
                div_divisor  = DIV_W'(n_eff);
            end
            ST_CAL_WAIT1:
            begin
                div_start    = div_done;
                div_dividend = {div_q[47:0], 16'd0};
                div_divisor  = DIV_W'(ratio_eff);
            end
            default:
            begin
                mul_a = 32'd0;
            end
        endcase
    end

    // Control state, configuration and persistent calibration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            supply_reg    <= 13'd5000;
            adc_ref_reg   <= 13'd3300;
            load_res_reg  <= 32'd655360;
            gain_reg      <= 32'd6553600;
            exponent_reg  <= 20'hE8000;
            threshold_reg <= 32'd128000;
            ratio_reg     <= RATIO_ONE;
            samples_reg   <= DEFAULT_SAMPLES;
            ro_reg        <= RO_RESET;
            cal_reg       <= 1'b0;
            acc_reg       <= 40'd0;
            cnt_reg       <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;

            // A new result replaces the one leaving; otherwise an accepted result clears.
            if ((state_reg == ST_FINISH) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SUPPLY:    supply_reg    <= cfg_data[12:0];
                    REG_ADC_REF:   adc_ref_reg   <= cfg_data[12:0];
                    REG_LOAD_RES:  load_res_reg  <= cfg_data;
                    REG_GAIN:
                    begin
                        if (cfg_data != 32'd0)
                        begin
                            gain_reg <= cfg_data;
                        end
                    end
                    REG_EXPONENT:  exponent_reg  <= cfg_data[19:0];
                    REG_THRESHOLD: threshold_reg <= cfg_data;
                    REG_RATIO:     ratio_reg     <= cfg_data[23:0];
                    REG_SAMPLES:   samples_reg   <= cfg_data[7:0];
                    default:       samples_reg   <= samples_reg;
                endcase
            end

            case (state_reg)
                ST_BRANCH:
                begin
                    if ((item_reg.op == OP_LOAD_RO) && (item_reg.ro_value != 32'd0))
                    begin
                        ro_reg  <= item_reg.ro_value;
                        cal_reg <= 1'b1;
                    end
                end
                ST_CAL_ACC:
                begin
                    acc_reg <= acc_sum;
                    cnt_reg <= cnt_reg + 8'd1;
                end
                ST_CAL_WAIT2:
                begin
                    if (div_done)
                    begin
                        ro_reg  <= ro_sat;
                        cal_reg <= 1'b1;
                        acc_reg <= 40'd0;
                        cnt_reg <= 8'd0;
                    end
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // Work registers of the current item.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                item_reg  <= in_data;
                ppm_reg   <= 32'd0;
                valid_reg <= 1'b0;
                alarm_reg <= 1'b0;
                done_reg  <= 1'b0;
            end
            ST_FULL:
            begin
                num_reg <= num_clamped;
            end
            ST_RL:
            begin
                rs_reg <= RS_MIN;
            end
            ST_RS_WAIT:
            begin
                if (div_done)
                begin
                    rs_reg <= rs_sat;
                end
            end
            ST_BRANCH:
            begin
                lm_reg    <= rs_reg;
                sh_reg    <= 5'd0;
                lg_ro_reg <= 1'b0;
                if ((item_reg.op == OP_LOAD_RO) && (item_reg.ro_value != 32'd0))
                begin
                    done_reg <= 1'b1;
                end
            end
            ST_LOG_NORM:
            begin
                if (lm_reg[31])
                begin
                    m_reg    <= lm_reg[31:1];
                    idx_reg  <= 4'd15;
                    frac_reg <= 16'd0;
                end
                else
                begin
                    lm_reg <= {lm_reg[30:0], 1'b0};
                    sh_reg <= sh_reg + 5'd1;
                end
            end
            ST_SQ_TAKE:
            begin
                m_reg    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                frac_reg <= frac_new;
                idx_reg  <= idx_reg - 4'd1;
                if (idx_reg == 4'd0)
                begin
                    if (lg_ro_reg)
                    begin
                        log_ro_reg <= log_new;
                    end
                    else
                    begin
                        log_rs_reg <= log_new;
                        lm_reg     <= ro_reg;
                        sh_reg     <= 5'd0;
                        lg_ro_reg  <= 1'b1;
                    end
                end
            end
            ST_EXP_TAKE:
            begin
                ei_reg <= prod_s[42:32];
                ef_reg <= prod_s[31:16];
                f_reg  <= ONE_Q30;
                j_reg  <= 4'd0;
            end
            ST_POW:
            begin
                if (!ef_reg[4'd15 - j_reg] && (j_reg != 4'd15))
                begin
                    j_reg <= j_reg + 4'd1;
                end
            end
            ST_POW_TAKE:
            begin
                f_reg <= prod[61:30];
                if (j_reg != 4'd15)
                begin
                    j_reg <= j_reg + 4'd1;
                end
            end
            ST_SCALE:
            begin
                ppm_reg   <= ppm_val;
                valid_reg <= 1'b1;
                alarm_reg <= ppm_val >= threshold_reg;
            end
            ST_CAL_WAIT2:
            begin
                if (div_done)
                begin
                    done_reg <= 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_reg.rs_kohm    <= rs_reg;
                    out_data_reg.ppm        <= ppm_reg;
                    out_data_reg.ppm_valid  <= valid_reg;
                    out_data_reg.alarm      <= alarm_reg;
                    out_data_reg.calib_done <= done_reg;
                    out_data_reg.calibrated <= cal_reg;
                end
            end
            default:
            begin
                item_reg <= item_reg;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // A valid concentration is only reported once Ro is known.
    a_valid_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.ppm_valid || out_data.calibrated))
        else $error("ppm_valid without calibration");

    // The alarm is only raised on a valid concentration.
    a_alarm_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.alarm || out_data.ppm_valid))
        else $error("alarm without valid ppm");

    // Rs is never below its floor of 0.001 kohm.
    a_rs_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.rs_kohm >= RS_MIN))
        else $error("rs_kohm below floor");

    // Completing calibration leaves the block calibrated.
    a_done_sets_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.calib_done || out_data.calibrated))
        else $error("calib_done without calibrated");
`endif

endmodule
